[src/lehmer_random_ranged_assert.svh]
// assertion macros for the ranged lehmer generator
`ifndef LEHMER_RANDOM_RANGED_ASSERT_SVH
`define LEHMER_RANDOM_RANGED_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lrr_pkg.sv]
// shared constants and controller/datapath interface types
package lrr_pkg;

    localparam int STATE_W  = 31;
    localparam int DATA_W   = 32;
    localparam int MULT_W   = 15;
    localparam int PROD_W   = STATE_W + MULT_W;
    localparam int SPAN_W   = 34;
    localparam int MAG_W    = 33;
    localparam int DIV_STEPS = STATE_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [MULT_W-1:0]  LCG_MULT  = 15'd16807;
    localparam logic [STATE_W-1:0] LCG_MOD   = 31'h7FFF_FFFF;
    localparam logic [STATE_W-1:0] SEED_RST  = 31'd1;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic calc_span;
        logic reduce;
        logic div_step;
        logic load_out;
    } lrr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic span_zero;
        logic out_free;
    } lrr_stat_t;

endpackage

[src/lrr_ctrl.sv]
// sequencer for one request: span, step, divide, deliver
module lrr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lrr_pkg::lrr_stat_t stat,
    output lrr_pkg::lrr_cmd_t  cmd
);
    import lrr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_RED,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_SPAN;
                end
                ST_SPAN:
                begin
                    state_reg <= ST_RED;
                end
                ST_RED:
                begin
                    if (stat.span_zero)
                        state_reg <= ST_OUT;
                    else
                    begin
                        cnt_reg   <= CNT_W'(DIV_STEPS - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= ST_OUT;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                ST_OUT:
                begin
                    if (stat.out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.load_in   = (state_reg == ST_IDLE) && in_valid;
        cmd.calc_span = (state_reg == ST_SPAN);
        cmd.reduce    = (state_reg == ST_RED) && !stat.span_zero;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.load_out  = (state_reg == ST_OUT) && stat.out_free;
    end

endmodule

[src/lrr_dpath.sv]
// generator state, span, modular step, radix-2 remainder and output register
module lrr_dpath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrr_pkg::lrr_cmd_t             cmd,
    output lrr_pkg::lrr_stat_t            stat,
    input  logic                          seed_wr_en,
    input  logic [lrr_pkg::STATE_W-1:0]   seed_wr_data,
    input  logic [2*lrr_pkg::DATA_W-1:0]  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lrr_pkg::STATE_W-1:0]   out_raw,
    output logic [lrr_pkg::DATA_W-1:0]    out_ranged,
    output logic                          out_advanced
);
    import lrr_pkg::*;

    logic [STATE_W-1:0] gen_state_reg;
    logic               out_valid_reg;

    logic [DATA_W-1:0]  lo_reg;
    logic [DATA_W-1:0]  hi_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               zero_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [STATE_W-1:0] quo_reg;
    logic [DATA_W-1:0]  rem_reg;
    logic [STATE_W-1:0] raw_reg;
    logic [DATA_W-1:0]  ranged_reg;
    logic               adv_reg;

    logic [SPAN_W-1:0]  span_next;
    logic [SPAN_W-1:0]  span_neg;
    logic [MAG_W-1:0]   mag_next;
    logic [PROD_W-1:0]  prod_next;
    logic [DATA_W-1:0]  fold_sum;
    logic [DATA_W-1:0]  fold_sub;
    logic [STATE_W-1:0] step_next;
    logic [MAG_W-1:0]   trial;
    logic [MAG_W-1:0]   trial_sub;
    logic [DATA_W-1:0]  rem_next;

    always_comb
    begin
        // span = hi + 1 - lo, exact at 34 bits
        span_next = {{2{hi_reg[DATA_W-1]}}, hi_reg} + SPAN_W'(1)
                  - {{2{lo_reg[DATA_W-1]}}, lo_reg};
        span_neg  = ~span_next + SPAN_W'(1);
        mag_next  = span_next[SPAN_W-1] ? span_neg[MAG_W-1:0] : span_next[MAG_W-1:0];
        prod_next = PROD_W'(gen_state_reg) * PROD_W'(LCG_MULT);

        // 2^31 == 1 mod (2^31-1): fold high part onto low part, one correction
        fold_sum  = {1'b0, prod_reg[STATE_W-1:0]}
                  + DATA_W'(prod_reg[PROD_W-1:STATE_W]);
        fold_sub  = fold_sum - {1'b0, LCG_MOD};
        step_next = (fold_sum >= {1'b0, LCG_MOD}) ? fold_sub[STATE_W-1:0]
                                                 : fold_sum[STATE_W-1:0];

        // restoring remainder step, one dividend bit per cycle
        trial     = {rem_reg, quo_reg[STATE_W-1]};
        trial_sub = trial - mag_reg;
        rem_next  = (trial >= mag_reg) ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state_reg <= SEED_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (seed_wr_en)
                gen_state_reg <= seed_wr_data;
            else if (cmd.reduce)
                gen_state_reg <= step_next;

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            lo_reg <= in_data[DATA_W-1:0];
            hi_reg <= in_data[2*DATA_W-1:DATA_W];
        end
        if (cmd.calc_span)
        begin
            mag_reg  <= mag_next;
            zero_reg <= (span_next == '0);
            prod_reg <= prod_next;
        end
        if (cmd.reduce)
        begin
            quo_reg <= step_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[STATE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.load_out)
        begin
            raw_reg    <= gen_state_reg;
            ranged_reg <= zero_reg ? lo_reg : lo_reg + rem_reg;
            adv_reg    <= !zero_reg;
        end
    end

    always_comb
    begin
        stat.span_zero = zero_reg;
        stat.out_free  = !out_valid_reg || out_ready;
        out_valid      = out_valid_reg;
        out_raw        = raw_reg;
        out_ranged     = ranged_reg;
        out_advanced   = adv_reg;
    end

endmodule

[src/lehmer_random_ranged.sv]
// top level of the ranged park-miller minimal-standard generator
//
// Each input word asks for one number in the inclusive range [range_low,
// range_high]. The generator steps state := 16807 * state mod (2^31 - 1) and
// answers the new raw value together with range_low + (raw mod |span|), where
// span = range_high + 1 - range_low taken without overflow. A span of zero
// (range_high + 1 == range_low) answers range_low, returns the current state
// as raw value and leaves the generator alone; advanced flags which case
// happened. A request with a nonzero span goes through span and product,
// modular fold, 31 steps of the radix-2 remainder unit and output load; a
// zero span skips the remainder steps. The next word can be taken in the
// cycle after the result loads; for a nonzero span the 31-step remainder
// loop sets the rate, unless the sink is slow to take the results.
// The block takes a new word only when the previous one has reached the
// output register, which may still be waiting for the sink. Writing the seed
// reloads the generator state; reset loads a seed of 1. Write the seed only
// while no request is in flight.
module lehmer_random_ranged
(
    input  logic        clk,
    input  logic        rst_n,
    // seed register write
    input  logic        seed_wr_en,
    input  logic [30:0] seed_wr_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] range_low, [63:32] range_high
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [30:0] raw_value, [62:31] ranged_value, [63] zero
    output logic        m_tuser    // [0] advanced
);
    import lrr_pkg::*;

    `include "lehmer_random_ranged_assert.svh"

    lrr_cmd_t           cmd;
    lrr_stat_t          stat;
    logic [STATE_W-1:0] raw;
    logic [DATA_W-1:0]  ranged;

    // sequencer: one request at a time
    lrr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // generator state, modular step, remainder unit, output register
    lrr_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .in_data      (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_raw      (raw),
        .out_ranged   (ranged),
        .out_advanced (m_tuser)
    );

    // pack result word, pad bit is zero
    assign m_tdata = {1'b0, ranged, raw};

    // after taking a word the block stays busy while it works on it
    `LRR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "accepted a second word while busy")

    // a stepped value is reduced fully and never equals the modulus
    `LRR_ASSERT_NOW(a_step_reduced, clk, rst_n, m_tvalid && m_tuser, m_tdata[30:0] != LCG_MOD, "stepped value not reduced")

    // an output load only happens into a free output register
    `LRR_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load_out, !m_tvalid || m_tready, "result overwritten before taken")

endmodule

[tb/tb_top.sv]
// self-checking testbench for the ranged park-miller generator
module tb_top;
    import lrr_pkg::*;

    // idle patterns applied to the request and result streams
    typedef enum logic [1:0] {
        IDLE_NONE   = 2'd0,
        IDLE_SENDER = 2'd1,
        IDLE_RECV   = 2'd2,
        IDLE_BOTH   = 2'd3
    } idle_mode_t;

    // one expected result word, split into its fields
    typedef struct packed {
        logic [STATE_W-1:0] raw;
        logic [DATA_W-1:0]  ranged;
        logic               advanced;
    } draw_t;

    localparam logic [63:0] PM_MULT    = 64'd16807;
    localparam logic [63:0] PM_MOD     = 64'd2147483647;
    localparam int          HOLD_LEN   = 400;
    localparam int          MAX_REPORT = 10;
    localparam int          TAIL_WAIT  = 50;

    logic        clk;
    logic        rst_n;
    logic        seed_wr_en;
    logic [30:0] seed_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;

    // predictor copy of the generator
    logic [STATE_W-1:0] lcg_state;

    logic [63:0] pending_q[$];  // request words not yet offered
    draw_t       draw_q[$];     // results predicted for accepted requests

    idle_mode_t idle_mode;
    int         fail_count;
    int         hold_seq;
    int         hold_seen;
    int         hold_left;

    lehmer_random_ranged dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),     // [31:0] range_low, [63:32] range_high
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),     // [30:0] raw_value, [62:31] ranged_value, [63] zero
        .m_tuser      (m_tuser)      // [0] advanced
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // predict the answer to one request and step the model generator unless the span is zero
    function automatic draw_t draw_ranged(input logic [63:0] req);
        logic [31:0]        lo;
        logic [31:0]        hi;
        logic signed [33:0] span;
        logic [33:0]        mag;
        logic [63:0]        prod;
        logic [63:0]        rem;
        draw_t              d;
        lo = req[31:0];
        hi = req[63:32];
        // span taken at 34 bits so high bound at maximum cannot overflow
        span = $signed({{2{hi[31]}}, hi}) + 34'sd1 - $signed({{2{lo[31]}}, lo});
        mag  = span[33] ? 34'(-span) : 34'(span);
        if (span == 34'sd0)
        begin
            // empty span: answer the low bound, generator stays put
            d.raw      = lcg_state;
            d.ranged   = lo;
            d.advanced = 1'b0;
        end
        else
        begin
            prod      = 64'(lcg_state) * PM_MULT;
            lcg_state = STATE_W'(prod % PM_MOD);
            rem       = 64'(lcg_state) % 64'(mag);
            d.raw      = lcg_state;
            d.ranged   = lo + rem[31:0];   // wraps modulo 2^32
            d.advanced = 1'b1;
        end
        return d;
    endfunction

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(99) < 80;
            IDLE_BOTH:   return $urandom_range(99) < 13;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < 80;
            IDLE_BOTH: return $urandom_range(99) < 13;
            default:   return 1'b0;
        endcase
    endfunction

    // request driver: valid stays up until the word is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                draw_q.push_back(draw_ranged(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_q.size() > 0 && !sender_rests())
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_q.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result ready, with an occasional long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= !receiver_stalls();
        end
    end

    // result monitor: compare each word taken with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (draw_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORT)
                    $display("unexpected result word: tdata %h tuser %b", m_tdata, m_tuser);
            end
            else
            begin
                draw_t want;
                want = draw_q.pop_front();
                if (m_tdata[30:0] !== want.raw || m_tdata[62:31] !== want.ranged
                    || m_tuser !== want.advanced)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                        $display("mismatch: raw %h/%h ranged %h/%h advanced %b/%b (exp/act)",
                                 want.raw, m_tdata[30:0], want.ranged, m_tdata[62:31],
                                 want.advanced, m_tuser);
                end
            end
        end
    end

    task automatic queue_request(input logic [31:0] lo, input logic [31:0] hi);
        pending_q.push_back({hi, lo});
    endtask

    // mostly spans with structure, some fully random bounds
    task automatic queue_random(input int count);
        logic [31:0] lo;
        logic [31:0] hi;
        int          pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            lo   = $urandom;
            if (pick < 35)
                hi = $urandom;
            else if (pick < 60)
                hi = lo + $urandom_range(0, 999);
            else if (pick < 72)
                hi = lo - 32'd1;
            else if (pick < 82)
                hi = lo - $urandom_range(2, 5000);
            else if (pick < 90)
            begin
                lo = 32'h8000_0000 + $urandom_range(0, 3);
                hi = 32'h7fff_ffff - $urandom_range(0, 3);
            end
            else if (pick < 95)
                hi = 32'h7fff_ffff;
            else
            begin
                lo = 32'h7fff_ffff - $urandom_range(0, 100);
                hi = $urandom;
            end
            queue_request(lo, hi);
        end
    endtask

    // wait for all requests to be taken and answered
    task automatic drain();
        wait (pending_q.size() == 0 && !s_tvalid && draw_q.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);
    endtask

    // seed write, only issued while the block is idle
    task automatic write_seed(input logic [30:0] value);
        @(posedge clk);
        seed_wr_en   <= 1'b1;
        seed_wr_data <= value;
        @(posedge clk);
        seed_wr_en   <= 1'b0;
        lcg_state = value;
    endtask

    task automatic run_phase(input idle_mode_t mode, input logic [30:0] seed_value,
                             input int count, input bit with_hold);
        write_seed(seed_value);
        @(negedge clk);
        idle_mode = mode;
        queue_random(count);
        // stall results for a long stretch while requests keep coming
        if (with_hold)
            hold_seq++;
        drain();
    endtask

    // stimulus sequence
    initial
    begin
        rst_n        = 1'b0;
        seed_wr_en   = 1'b0;
        seed_wr_data = '0;
        idle_mode    = IDLE_NONE;
        fail_count   = 0;
        hold_seq     = 0;
        lcg_state    = SEED_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests from the reset seed
        queue_request(32'd0, 32'd9);
        queue_request(32'd0, 32'd0);             // span of one
        queue_request(32'd5, 32'd4);             // empty span
        queue_request(32'd0, 32'hffff_ffff);     // empty span at zero
        queue_request(32'h8000_0000, 32'h7fff_ffff);  // widest span
        queue_request(32'd0, 32'h7fff_ffff);     // high bound at maximum
        queue_request(32'hffff_ffff, 32'h7fff_ffff);
        queue_request(32'd100, -32'd100);        // reversed bounds
        queue_request(32'h7fff_ff9c, 32'h8000_0000);  // sum wraps past maximum
        queue_request(32'h7fff_ffff, 32'h7fff_ffff);
        queue_request(32'h7fff_ffff, 32'h7fff_fffe);  // empty span at top
        queue_request(32'h8000_0000, 32'h8000_0000);
        queue_request(32'h8000_0000, 32'h7fff_fffe);
        queue_request(32'h7fff_ffff, 32'h8000_0000);
        queue_request(-32'd50, -32'd1);
        queue_request(32'd1, 32'd2);
        queue_request(32'd0, 32'd1);
        queue_request(32'hffff_ffff, 32'hffff_ffff);
        queue_request(32'h8000_0001, 32'h8000_0000);  // empty span at bottom
        queue_request(32'h5555_5555, 32'haaaa_aaaa);
        queue_request(32'haaaa_aaaa, 32'h5555_5555);
        drain();

        // degenerate seeds: zero sticks, the modulus falls to zero
        write_seed(31'd0);
        @(negedge clk);
        idle_mode = IDLE_SENDER;
        queue_request(32'd0, 32'd9);
        queue_request(32'd7, 32'd6);
        queue_random(8);
        drain();
        write_seed(31'h7fff_ffff);
        @(negedge clk);
        idle_mode = IDLE_RECV;
        queue_request(32'd0, 32'd9);
        queue_request(-32'd3, 32'd3);
        queue_random(8);
        drain();

        // random phases over every idle pattern and several seeds
        run_phase(IDLE_NONE,   31'd2147483646, 120, 1'b1);
        run_phase(IDLE_SENDER, 31'd1, 120, 1'b0);
        run_phase(IDLE_RECV,   31'($urandom_range(1, 2147483646)), 120, 1'b0);
        run_phase(IDLE_BOTH,   31'($urandom_range(1, 2147483646)), 120, 1'b0);
        run_phase(IDLE_NONE,   31'($urandom_range(1, 2147483646)), 120, 1'b0);
        run_phase(IDLE_BOTH,   31'($urandom_range(1, 1000)), 120, 1'b1);
        run_phase(IDLE_RECV,   31'($urandom), 120, 1'b0);
        run_phase(IDLE_SENDER, 31'($urandom), 120, 1'b0);

        if (fail_count == 0 && draw_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
